[sv/hpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the max-heap priority queue.
// No dependencies; every other file of the block imports this package.
package hpq_pkg;

	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 8;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [STAT_W-1:0]        status;
		logic [COUNT_W-1:0]       element_count;
	} res_t;

	// Operation broadcast to every cell at once.
	typedef struct packed {
		logic                     ins;
		logic                     ext;
		logic signed [DATA_W-1:0] value;
	} ctrl_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     occ;
		logic                     take;
	} link_t;

endpackage

[sv/hpq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a value and an occupied flag.
// Depends on hpq_pkg for the control and neighbor link types.
module hpq_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  hpq_pkg::ctrl_t ctrl,
	input  hpq_pkg::link_t prev,
	input  hpq_pkg::link_t next,
	output hpq_pkg::link_t self
);
	import hpq_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic                     occ_q;
	logic                     take;

	// The new value lands at or ahead of this slot when the slot is free
	// or holds something strictly smaller.
	assign take = !occ_q || (ctrl.value > value_q);

	assign self.value = value_q;
	assign self.occ   = occ_q;
	assign self.take  = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.ins) begin
			occ_q <= prev.occ;
		end else if (ctrl.ext) begin
			occ_q <= next.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (take) begin
				value_q <= prev.take ? prev.value : ctrl.value;
			end
		end else if (ctrl.ext) begin
			value_q <= next.value;
		end
	end

endmodule

[sv/max_heap_priority_queue_top.sv]
`timescale 1ns / 1ps
// Bounded max priority queue of signed 32-bit values.
// Depends on hpq_pkg and hpq_cell.
//
// Usage: a request on the cmd channel carries either an insert (command 0,
// with a value) or an extract of the largest stored value (command 1).
// Every request yields exactly one response on the res channel holding the
// extracted value (zero for inserts and errors), a status (ok, full, empty)
// and the element count after the operation, modulo 256.
//
// The store is a row of CAPACITY cells kept in descending order. An insert
// is broadcast to all cells at once; each cell either keeps its value,
// takes the new one, or takes its left neighbor's value. An extract shifts
// every cell one place toward the head, so the head cell always holds the
// maximum.
//
// The response is registered and appears in the cycle after the request is
// accepted; one request per cycle is taken while the response register is
// empty or being drained. When the receiver stalls, the response is held and
// cmd_ready drops until it is taken. Reset empties the queue at once; no clearing pass is needed.
// Rejected inserts and extracts from an empty queue leave the state alone.
module max_heap_priority_queue_top #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  hpq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output hpq_pkg::res_t res
);
	import hpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          res_valid_q;
	res_t          res_q;

	logic          accept;
	logic          full;
	logic          empty;
	ctrl_t         ctrl;
	link_t         links [CAPACITY];
	logic [CW-1:0] count_d;
	logic [CW+COUNT_W-1:0] count_ext;
	res_t          res_d;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	// Occupancy of the tail and head cells tells full and empty directly.
	assign full  = links[CAPACITY-1].occ;
	assign empty = !links[0].occ;

	assign ctrl.ins   = accept && (cmd.command == CMD_INSERT) && !full;
	assign ctrl.ext   = accept && (cmd.command == CMD_EXTRACT) && !empty;
	assign ctrl.value = cmd.value;

	// The chain: the head sees an always-occupied slot that never takes,
	// the tail sees an empty neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t prev_link;
		link_t next_link;

		if (i == 0) begin : g_head
			assign prev_link = '{value: '0, occ: 1'b1, take: 1'b0};
		end else begin : g_mid
			assign prev_link = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_link = '{value: '0, occ: 1'b0, take: 1'b0};
		end else begin : g_body
			assign next_link = links[i+1];
		end

		hpq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.prev  (prev_link),
			.next  (next_link),
			.self  (links[i])
		);
	end

	always_comb begin
		count_d            = count_q;
		res_d.result_value = '0;
		res_d.status       = ST_OK;
		if (cmd.command == CMD_INSERT) begin
			if (full) begin
				res_d.status = ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				res_d.status = ST_EMPTY;
			end else begin
				res_d.result_value = links[0].value;
				count_d            = count_q - CW'(1);
			end
		end
		count_ext           = {{COUNT_W{1'b0}}, count_d};
		res_d.element_count = count_ext[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[sv/hpq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the priority queue, bound to the top level.
// Depends on hpq_pkg and max_heap_priority_queue_top.
module hpq_checker #(
	parameter int CAPACITY = 128
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input hpq_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_ready,
	input hpq_pkg::res_t res
);
	import hpq_pkg::*;

	// A stalled response must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("response changed while stalled");

	// A fresh response only follows an accepted request.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && cmd_ready))
		else $error("response without a request");

	// Error responses never return a value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |-> res.result_value == '0)
		else $error("nonzero value on error status");

	// An empty error reports an empty queue; a full error a full one.
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_EMPTY) |-> res.element_count == '0)
		else $error("empty error with nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_FULL) |->
			res.element_count == COUNT_W'(CAPACITY % 256))
		else $error("full error with wrong count");

endmodule

bind max_heap_priority_queue_top hpq_checker #(.CAPACITY(CAPACITY)) u_hpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd      (cmd),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);

[verif/max_heap_priority_queue_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for max_heap_priority_queue_top: a directed table, then random
// insert/extract traffic with random idling on both channels. Depends on hpq_pkg and the block.
module max_heap_priority_queue_top_test;
	import hpq_pkg::*;

	localparam int CAPACITY     = 128;
	localparam int RANDOM_ITEMS = 1600;
	// The block answers in the cycle after it takes a request; this settle wait is long enough to
	// catch a stray response once the last expected one has come back.
	localparam int SETTLE_CYCLES = 16;
	// Long receiver hold-off used to back the block up and stall its request side.
	localparam int LONG_HOLD = 300;
	// Guard against a hung handshake. A correct run ends far below this.
	localparam int RUN_LIMIT_NS = 10_000_000;

	typedef enum int {
		PH_MIXED,
		PH_FILL,
		PH_DRAIN,
		PH_BACKPRESSURE
	} phase_e;

	// One row of the directed table. When has_want is set the expected response is typed in
	// the row; otherwise the heap predictor supplies it.
	typedef struct {
		cmd_t req;
		bit   has_want;
		res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	// The directed expectation travels with the request and is held stable alongside it.
	bit   dir_has_want;
	res_t dir_want;

	// Shared control between the sender, the receiver and the checker.
	bit steady;
	bit hold_req;
	int errors;

	// Predictor state: a copy of the heap, in heap order from index 0.
	int heap_vals [CAPACITY];
	int heap_len;

	res_t     expected_q [$];
	dir_row_t dir_table [$];

	max_heap_priority_queue_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #4 clk = ~clk;

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		dir_has_want = 1'b0;
		dir_want     = '0;
		res_ready    = 1'b0;
		steady       = 1'b0;
		hold_req     = 1'b0;
		errors       = 0;
		heap_len     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("max_heap_priority_queue_top_test: errors");
		$finish;
	end

	// Applies one request to the predicted heap and returns the response it should produce.
	// An insert goes at the end and bubbles up while strictly larger than its parent; an
	// extract takes the root, moves the last entry up and pushes it down toward the larger
	// child, the left child winning a tie. Full and empty cases leave the heap untouched.
	function automatic res_t heap_apply(cmd_t req);
		res_t r;
		int   pos;
		int   up;
		int   best;
		int   lc;
		int   rc;
		int   tmp;
		bit   moving;
		r = '0;
		r.status = ST_OK;
		if (req.command == CMD_INSERT) begin
			if (heap_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = heap_len;
				heap_vals[pos] = req.value;
				heap_len++;
				moving = 1'b1;
				while (moving && pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_vals[pos] > heap_vals[up]) begin
						tmp = heap_vals[pos];
						heap_vals[pos] = heap_vals[up];
						heap_vals[up] = tmp;
						pos = up;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (heap_len == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.result_value = heap_vals[0];
				heap_len--;
				heap_vals[0] = heap_vals[heap_len];
				pos = 0;
				moving = 1'b1;
				while (moving && pos < heap_len) begin
					best = pos;
					lc = 2 * pos + 1;
					rc = lc + 1;
					if (lc < heap_len && heap_vals[lc] > heap_vals[best])
						best = lc;
					if (rc < heap_len && heap_vals[rc] > heap_vals[best])
						best = rc;
					if (best == pos) begin
						moving = 1'b0;
					end else begin
						tmp = heap_vals[pos];
						heap_vals[pos] = heap_vals[best];
						heap_vals[best] = tmp;
						pos = best;
					end
				end
			end
		end
		r.element_count = COUNT_W'(heap_len);
		return r;
	endfunction

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Values lean on the extremes and on a narrow band so that duplicates are common;
	// the rest are full 32-bit random patterns so every bit toggles.
	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 32'sh7FFF_FFFF;
		else if (roll < 6)
			return 32'sh8000_0000;
		else if (roll < 8)
			return 32'sd0;
		else if (roll < 10)
			return -32'sd1;
		else if (roll < 35)
			return $signed(32'($urandom_range(0, 16)) - 32'd8);
		else
			return $signed(32'($urandom));
	endfunction

	task automatic flag_mismatch(string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic add_row(logic command, logic signed [DATA_W-1:0] value, bit has_want,
		logic signed [DATA_W-1:0] want_value, logic [STAT_W-1:0] want_status,
		logic [COUNT_W-1:0] want_count);
		dir_row_t row;
		row.req.command          = command;
		row.req.value            = value;
		row.has_want             = has_want;
		row.want.result_value    = want_value;
		row.want.status          = want_status;
		row.want.element_count   = want_count;
		dir_table.push_back(row);
	endtask

	// Called at a falling edge. Idles for a random gap (none while steady), then holds the request
	// until it is taken, and returns at the falling edge after acceptance. The valid line is only ever
	// written once per time step: lowered on the first gap cycle, raised after the gap.
	task automatic send_request(cmd_t req, bit has_want, res_t want);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid    <= 1'b1;
		cmd          <= req;
		dir_has_want <= has_want;
		dir_want     <= want;
		do
			@(posedge clk);
		while (!cmd_ready);
		@(negedge clk);
	endtask

	task automatic send_random(logic command);
		cmd_t req;
		req.command = command;
		req.value   = pick_value();
		send_request(req, 1'b0, '0);
	endtask

	// Holds the sender back until every outstanding response has been seen.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver side. A requested long hold-off is counted here in its own cycles; otherwise
	// ready drops for random gaps, or stays high throughout while the traffic runs steady.
	initial begin : receiver
		int idle_cycles;
		int hold_cycles;
		idle_cycles = 0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_ready <= 1'b0;
				hold_cycles--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cycles = LONG_HOLD - 1;
				res_ready <= 1'b0;
			end else if (idle_cycles > 0) begin
				res_ready <= 1'b0;
				idle_cycles--;
			end else begin
				res_ready <= 1'b1;
				idle_cycles = steady ? 0 : pick_gap();
			end
		end
	end

	// Checker. Every accepted request is run through the predictor at the edge that takes
	// it; a typed-in directed expectation replaces the predicted one but the predicted heap
	// still advances. Every accepted response is compared with the oldest expectation.
	always @(posedge clk) begin
		res_t predicted;
		res_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				predicted = heap_apply(cmd);
				expected_q.push_back(dir_has_want ? dir_want : predicted);
			end
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					flag_mismatch($sformatf("response with nothing outstanding: value %0d status %0d count %0d",
						res.result_value, res.status, res.element_count));
				end else begin
					want = expected_q.pop_front();
					if (res.result_value !== want.result_value)
						flag_mismatch($sformatf("result_value %0d, expected %0d",
							res.result_value, want.result_value));
					if (res.status !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							res.status, want.status));
					if (res.element_count !== want.element_count)
						flag_mismatch($sformatf("element_count %0d, expected %0d",
							res.element_count, want.element_count));
				end
			end
		end
	end

	initial begin : stimulus
		int     sent;
		int     phase_num;
		int     len;
		int     insert_pct;
		int     extra;
		phase_e kind;

		// Directed part: empty extract, the two extremes in and out, the ignored value on an
		// extract, and then a batch with ties and both extremes drained back to empty.
		add_row(CMD_EXTRACT, 32'sd0,           1'b1, 32'sd0,           ST_EMPTY, 8'd0);
		add_row(CMD_INSERT,  32'sh7FFF_FFFF,   1'b1, 32'sd0,           ST_OK,    8'd1);
		add_row(CMD_INSERT,  32'sh8000_0000,   1'b1, 32'sd0,           ST_OK,    8'd2);
		add_row(CMD_EXTRACT, 32'sd0,           1'b1, 32'sh7FFF_FFFF,   ST_OK,    8'd1);
		add_row(CMD_EXTRACT, 32'sd0,           1'b1, 32'sh8000_0000,   ST_OK,    8'd0);
		add_row(CMD_EXTRACT, -32'sd1,          1'b1, 32'sd0,           ST_EMPTY, 8'd0);
		add_row(CMD_INSERT,  32'sd0,           1'b1, 32'sd0,           ST_OK,    8'd1);
		add_row(CMD_INSERT,  -32'sd1,          1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sd1,           1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sd5,           1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sd5,           1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sd5,           1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  -32'sd5,          1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sh7FFF_FFFF,   1'b0, '0, ST_OK, '0);
		add_row(CMD_INSERT,  32'sh8000_0000,   1'b0, '0, ST_OK, '0);
		repeat (9)
			add_row(CMD_EXTRACT, 32'sh5A5A_A5A5, 1'b0, '0, ST_OK, '0);
		add_row(CMD_EXTRACT, 32'sd0,           1'b1, 32'sd0,           ST_EMPTY, 8'd0);

		@(posedge arst_n);
		@(negedge clk);
		foreach (dir_table[i])
			send_request(dir_table[i].req, dir_table[i].has_want, dir_table[i].want);

		// Random part, in phases. The first three are fixed: fill to capacity and beyond,
		// pause until drained, empty it and beyond, then a long receiver hold-off while
		// requests keep coming. After that the phase kinds are drawn at random.
		sent = 0;
		phase_num = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_num == 0)
				kind = PH_FILL;
			else if (phase_num == 1)
				kind = PH_DRAIN;
			else if (phase_num == 2)
				kind = PH_BACKPRESSURE;
			else begin
				len = $urandom_range(0, 99);
				kind = (len < 60) ? PH_MIXED : (len < 78) ? PH_FILL :
					(len < 96) ? PH_DRAIN : PH_BACKPRESSURE;
			end
			steady = ($urandom_range(0, 4) == 0);

			case (kind)
				PH_FILL: begin
					while (heap_len < CAPACITY) begin
						send_random(CMD_INSERT);
						sent++;
					end
					// A few inserts against a full heap, with the odd extract between.
					extra = $urandom_range(3, 8);
					repeat (extra) begin
						send_random(($urandom_range(0, 5) == 0) ? CMD_EXTRACT : CMD_INSERT);
						sent++;
					end
				end
				PH_DRAIN: begin
					while (heap_len > 0) begin
						send_random(CMD_EXTRACT);
						sent++;
					end
					extra = $urandom_range(2, 5);
					repeat (extra) begin
						send_random(($urandom_range(0, 5) == 0) ? CMD_INSERT : CMD_EXTRACT);
						sent++;
					end
				end
				PH_BACKPRESSURE: begin
					steady = 1'b1;
					hold_req = 1'b1;
					repeat (40) begin
						send_random(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_EXTRACT);
						sent++;
					end
				end
				default: begin
					len = $urandom_range(20, 150);
					insert_pct = $urandom_range(30, 70);
					repeat (len) begin
						send_random(($urandom_range(0, 99) < insert_pct) ?
							CMD_INSERT : CMD_EXTRACT);
						sent++;
					end
				end
			endcase

			if (phase_num == 0 || $urandom_range(0, 5) == 0)
				wait_drained();
			phase_num++;
		end

		// Wind down: stop requesting, wait for the last response, then watch for strays.
		steady = 1'b0;
		cmd_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("max_heap_priority_queue_top_test: clean");
		else
			$display("max_heap_priority_queue_top_test: errors");
		$finish;
	end

endmodule
